// ===== rtl/apc_pkg.sv =====
package apc_pkg;

  localparam int unsigned ValueWidthDefault = 16;
  localparam int unsigned CountWidthDefault = 16;

  // The total divisor count of a pair saturates here.
  localparam logic [7:0] TotalMax = 8'd255;

  // Lane sequencer states.
  typedef enum logic [3:0] {
    LANE_IDLE = 4'b0001,
    LANE_TEST = 4'b0010,
    LANE_DIV  = 4'b0100,
    LANE_DONE = 4'b1000
  } lane_state_e;

  // Widths of the candidate divisor, the raw divisor sum and the divisor count.
  function automatic int unsigned cand_width(int unsigned value_width);
    return (value_width + 1) / 2 + 2;
  endfunction

  function automatic int unsigned sum_width(int unsigned value_width);
    return value_width + 3;
  endfunction

  function automatic int unsigned cnt_width(int unsigned value_width);
    return (value_width + 1) / 2 + 3;
  endfunction

endpackage

// ===== rtl/amicable_pair_checker.sv =====
// Amicable pair checker. Each request carries two numbers; two lanes
// sum and count the proper divisors of each number at the same time by trial
// division, and a merging stage flags the pair as amicable when each divisor
// sum equals the other number. Every request gives exactly one result: the
// amicable flag, a saturating count of amicable pairs so far, and the amicable
// pair seen so far with the fewest proper divisors in total (the first one
// wins a tie), with best_valid low until any amicable pair has turned up.
// A lane tests candidate divisors d with d*d <= n through its own restoring
// divider, which yields one quotient bit per cycle; each candidate passes an
// issue step, the divide steps and a step that adds the divisors in. One
// request is worked on at a time, and the next one can be taken once the
// result has been registered. A finished result sits in an output register,
// and the next request is taken while it waits there.
module amicable_pair_checker #(
  parameter int unsigned VALUE_WIDTH = apc_pkg::ValueWidthDefault,
  parameter int unsigned COUNT_WIDTH = apc_pkg::CountWidthDefault
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // Fields from bit 0 up: first_value, second_value, zero padding.
  input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]         s_axis_tdata_i,
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  // Fields from bit 0 up: pair_is_amicable, amicable_count, best_valid,
  // fewest_divisors, best_first, best_second, zero padding.
  output logic [((2*VALUE_WIDTH+COUNT_WIDTH+10+7)/8)*8-1:0] m_axis_tdata_o
);
  import apc_pkg::*;

  localparam int unsigned OutWidth = ((2 * VALUE_WIDTH + COUNT_WIDTH + 10 + 7) / 8) * 8;
  localparam int unsigned SW = sum_width(VALUE_WIDTH);
  localparam int unsigned CW = cnt_width(VALUE_WIDTH);

  // Request side: the pair is held here while both lanes run.
  logic                   busy_q, busy_d;
  logic [VALUE_WIDTH-1:0] first_q, second_q;
  logic                   in_accept;
  logic                   fire;

  // Lane results.
  logic                   done_first, done_second;
  logic [SW-1:0]          sum_first, sum_second;
  logic [CW-1:0]          cnt_first, cnt_second;

  // Merged result for the current pair.
  logic                   res_amicable;
  logic [COUNT_WIDTH-1:0] res_count;
  logic                   res_valid;
  logic [7:0]             res_fewest;
  logic [VALUE_WIDTH-1:0] res_first, res_second;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic                   out_amicable_q;
  logic [COUNT_WIDTH-1:0] out_count_q;
  logic                   out_best_q;
  logic [7:0]             out_fewest_q;
  logic [VALUE_WIDTH-1:0] out_first_q, out_second_q;

  assign s_axis_tready_o = !busy_q;
  assign in_accept       = s_axis_tvalid_i && !busy_q;

  // Both lanes finished and the output register has room for the result.
  assign fire = busy_q && done_first && done_second && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    busy_d = busy_q;
    if (in_accept) begin
      busy_d = 1'b1;
    end else if (fire) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      first_q  <= s_axis_tdata_i[VALUE_WIDTH-1:0];
      second_q <= s_axis_tdata_i[2*VALUE_WIDTH-1:VALUE_WIDTH];
    end
  end

  apc_lane #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_lane_first (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_accept),
    .value_i(s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .done_o (done_first),
    .sum_o  (sum_first),
    .count_o(cnt_first)
  );

  apc_lane #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_lane_second (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_accept),
    .value_i(s_axis_tdata_i[2*VALUE_WIDTH-1:VALUE_WIDTH]),
    .done_o (done_second),
    .sum_o  (sum_second),
    .count_o(cnt_second)
  );

  apc_merge #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .first_i      (first_q),
    .second_i     (second_q),
    .sum_first_i  (sum_first),
    .sum_second_i (sum_second),
    .cnt_first_i  (cnt_first),
    .cnt_second_i (cnt_second),
    .amicable_o   (res_amicable),
    .count_o      (res_count),
    .best_valid_o (res_valid),
    .fewest_o     (res_fewest),
    .best_first_o (res_first),
    .best_second_o(res_second)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      out_amicable_q <= 1'b0;
      out_count_q    <= '0;
      out_best_q     <= 1'b0;
      out_fewest_q   <= '0;
      out_first_q    <= '0;
      out_second_q   <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        out_amicable_q <= res_amicable;
        out_count_q    <= res_count;
        out_best_q     <= res_valid;
        out_fewest_q   <= res_fewest;
        out_first_q    <= res_first;
        out_second_q   <= res_second;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutWidth'({out_second_q, out_first_q, out_fewest_q, out_best_q,
                                      out_count_q, out_amicable_q});

`ifndef SYNTH
  // A result is never written over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (!out_valid_q || m_axis_tready_i))
    else $error("result register overwritten");

  // The output register only becomes valid through the merging stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire))
    else $error("result appeared without a merge");

  // Once a best pair exists it never goes away.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_best_q |=> out_best_q)
    else $error("best pair lost");

  // The amicable count never falls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |=> (out_count_q >= $past(out_count_q)))
    else $error("amicable count decreased");
`endif

endmodule

// ===== rtl/apc_div.sv =====
module apc_div #(
  parameter int unsigned VALUE_WIDTH = apc_pkg::ValueWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [VALUE_WIDTH-1:0] remainder_o
);
  import apc_pkg::*;

  localparam int unsigned StepWidth = $clog2(VALUE_WIDTH + 1);

  logic [StepWidth-1:0]   step_q, step_d;
  logic                   done_q, done_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] dvs_q, dvs_d;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
    trial   = shifted - {1'b0, dvs_q};
    step_d  = step_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    done_d  = 1'b0;
    if (start_i) begin
      step_d = StepWidth'(VALUE_WIDTH);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (step_q != '0) begin
      step_d = step_q - 1'b1;
      done_d = (step_q == StepWidth'(1));
      if (!trial[VALUE_WIDTH]) begin
        rem_d = trial[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== rtl/apc_lane.sv =====
module apc_lane #(
  parameter int unsigned VALUE_WIDTH = apc_pkg::ValueWidthDefault
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [VALUE_WIDTH-1:0]                      value_i,
  output logic                                        done_o,
  output logic [apc_pkg::sum_width(VALUE_WIDTH)-1:0]  sum_o,
  output logic [apc_pkg::cnt_width(VALUE_WIDTH)-1:0]  count_o
);
  import apc_pkg::*;

  localparam int unsigned DW = cand_width(VALUE_WIDTH);
  localparam int unsigned SW = sum_width(VALUE_WIDTH);
  localparam int unsigned CW = cnt_width(VALUE_WIDTH);
  localparam int unsigned QW = VALUE_WIDTH + 2;

  lane_state_e            state_q, state_d;
  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [DW-1:0]          d_q, d_d;
  logic [QW-1:0]          sq_q, sq_d;
  logic [SW-1:0]          s_q, s_d;
  logic [CW-1:0]          c_q, c_d;

  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] d_ext;
  logic                   pair_div;

  assign d_ext    = {{(VALUE_WIDTH - DW){1'b0}}, d_q};
  assign pair_div = (quo != d_ext);

  apc_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_ext),
    .done_o     (div_done),
    .quotient_o (quo),
    .remainder_o(rem)
  );

  // Candidates run while d*d <= n; the square is kept by adding 2d+1.
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    d_d       = d_q;
    sq_d      = sq_q;
    s_d       = s_q;
    c_d       = c_q;
    div_start = 1'b0;
    if (start_i) begin
      state_d = LANE_TEST;
      n_d     = value_i;
      d_d     = DW'(1);
      sq_d    = QW'(1);
      s_d     = '0;
      c_d     = '0;
    end else begin
      case (state_q)
        LANE_IDLE: begin
          state_d = LANE_IDLE;
        end
        LANE_TEST: begin
          if (n_q == '0) begin
            s_d     = '0;
            c_d     = '0;
            state_d = LANE_DONE;
          end else if (sq_q > {2'b00, n_q}) begin
            // The value itself is not a proper divisor.
            s_d     = s_q - {3'b000, n_q};
            c_d     = c_q - 1'b1;
            state_d = LANE_DONE;
          end else begin
            div_start = 1'b1;
            state_d   = LANE_DIV;
          end
        end
        LANE_DIV: begin
          if (div_done) begin
            if (rem == '0) begin
              s_d = s_q + SW'(d_q) + (pair_div ? SW'(quo) : SW'(0));
              c_d = c_q + CW'(1) + CW'(pair_div);
            end
            d_d     = d_q + 1'b1;
            sq_d    = sq_q + {{(QW - DW - 1){1'b0}}, d_q, 1'b1};
            state_d = LANE_TEST;
          end
        end
        LANE_DONE: begin
          state_d = LANE_DONE;
        end
        default: begin
          state_d = LANE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LANE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    d_q  <= d_d;
    sq_q <= sq_d;
    s_q  <= s_d;
    c_q  <= c_d;
  end

  assign done_o  = (state_q == LANE_DONE);
  assign sum_o   = s_q;
  assign count_o = c_q;

endmodule

// ===== rtl/apc_merge.sv =====
module apc_merge #(
  parameter int unsigned VALUE_WIDTH = apc_pkg::ValueWidthDefault,
  parameter int unsigned COUNT_WIDTH = apc_pkg::CountWidthDefault
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       fire_i,
  input  logic [VALUE_WIDTH-1:0]                     first_i,
  input  logic [VALUE_WIDTH-1:0]                     second_i,
  input  logic [apc_pkg::sum_width(VALUE_WIDTH)-1:0] sum_first_i,
  input  logic [apc_pkg::sum_width(VALUE_WIDTH)-1:0] sum_second_i,
  input  logic [apc_pkg::cnt_width(VALUE_WIDTH)-1:0] cnt_first_i,
  input  logic [apc_pkg::cnt_width(VALUE_WIDTH)-1:0] cnt_second_i,
  output logic                                       amicable_o,
  output logic [COUNT_WIDTH-1:0]                     count_o,
  output logic                                       best_valid_o,
  output logic [7:0]                                 fewest_o,
  output logic [VALUE_WIDTH-1:0]                     best_first_o,
  output logic [VALUE_WIDTH-1:0]                     best_second_o
);
  import apc_pkg::*;

  localparam int unsigned CW = cnt_width(VALUE_WIDTH);

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   have_q, have_d;
  logic [7:0]             least_q, least_d;
  logic [VALUE_WIDTH-1:0] first_q, first_d;
  logic [VALUE_WIDTH-1:0] second_q, second_d;

  logic                   amicable;
  logic [CW:0]            total;
  logic [7:0]             total_sat;
  logic                   take_best;

  always_comb begin
    amicable  = (sum_first_i == {3'b000, second_i}) && (sum_second_i == {3'b000, first_i});
    total     = {1'b0, cnt_first_i} + {1'b0, cnt_second_i};
    total_sat = (total > (CW + 1)'(TotalMax)) ? TotalMax : total[7:0];
    take_best = fire_i && amicable && (!have_q || (total_sat < least_q));

    count_d  = count_q;
    have_d   = have_q;
    least_d  = least_q;
    first_d  = first_q;
    second_d = second_q;
    if (fire_i && amicable && (count_q != '1)) begin
      count_d = count_q + 1'b1;
    end
    if (take_best) begin
      have_d   = 1'b1;
      least_d  = total_sat;
      first_d  = first_i;
      second_d = second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      have_q   <= 1'b0;
      least_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      count_q  <= count_d;
      have_q   <= have_d;
      least_q  <= least_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  // The result carries the state as it stands after this pair.
  assign amicable_o    = amicable;
  assign count_o       = count_d;
  assign best_valid_o  = have_d;
  assign fewest_o      = least_d;
  assign best_first_o  = first_d;
  assign best_second_o = second_d;

endmodule

// ===== tb/amicable_pair_checker_tb.sv =====
`timescale 1ns / 100ps

module amicable_pair_checker_tb;

  localparam int unsigned VW = apc_pkg::ValueWidthDefault;
  localparam int unsigned CW = apc_pkg::CountWidthDefault;
  localparam int unsigned InWidth = ((2*VW+7)/8)*8;
  localparam int unsigned OutWidth = ((2*VW+CW+10+7)/8)*8;
  localparam logic [CW-1:0] CountMax = '1;

  localparam int unsigned NumDirected = 24;
  localparam int unsigned NumRandom = 80;
  localparam int unsigned HoldOffAfter = 25;
  // Long enough for two of the slowest requests, so the block fills and stalls its input.
  localparam int unsigned HoldOffCycles = 12000;
  localparam int unsigned PauseAt = 40;
  localparam int unsigned CalmFrom = 50;
  localparam int unsigned CalmTo = 75;
  // Let more time than the slowest request takes pass at the end.
  localparam int unsigned SettleCycles = 5000;
  localparam int unsigned StallLimit = 50000;
  localparam int unsigned IdlePercent = 12;
  localparam int unsigned MaxReported = 10;

  // Laid out so that the struct maps straight onto the low bits of the result word.
  typedef struct packed {
    logic [VW-1:0] best_second;
    logic [VW-1:0] best_first;
    logic [7:0]    fewest;
    logic          best_valid;
    logic [CW-1:0] count;
    logic          amicable;
  } pair_result_t;

  typedef struct packed {
    logic [VW-1:0] a_value;
    logic [VW-1:0] b_value;
    logic          typed;
    pair_result_t  result;
  } stim_row_t;

  localparam pair_result_t NoneYet = '0;

  // Rows with typed set are checked against the result written here; the rest against
  // the predictor. The typed rows all come before any amicable pair, so nothing is set yet.
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{16'd1,     16'd1,     1'b1, NoneYet},
    '{16'd65535, 16'd65535, 1'b1, NoneYet},
    '{16'd0,     16'd65535, 1'b1, NoneYet},
    '{16'd65535, 16'd0,     1'b1, NoneYet},
    // Only one side matches: the divisor sum of one is zero, that of zero is not one.
    '{16'd1,     16'd0,     1'b1, NoneYet},
    '{16'd0,     16'd1,     1'b1, NoneYet},
    '{16'd2,     16'd3,     1'b1, NoneYet},
    '{16'd220,   16'd284,   1'b0, NoneYet},
    // Same total as the pair before it, so the first one has to stay.
    '{16'd284,   16'd220,   1'b0, NoneYet},
    '{16'd220,   16'd220,   1'b0, NoneYet},
    '{16'd12285, 16'd14595, 1'b0, NoneYet},
    '{16'd17296, 16'd18416, 1'b0, NoneYet},
    '{16'd6232,  16'd6368,  1'b0, NoneYet},
    '{16'd1184,  16'd1210,  1'b0, NoneYet},
    // Perfect numbers given twice count as amicable.
    '{16'd6,     16'd6,     1'b0, NoneYet},
    '{16'd28,    16'd28,    1'b0, NoneYet},
    '{16'd6,     16'd6,     1'b0, NoneYet},
    '{16'd496,   16'd496,   1'b0, NoneYet},
    '{16'd8128,  16'd8128,  1'b0, NoneYet},
    '{16'd6,     16'd28,    1'b0, NoneYet},
    '{16'd65534, 16'd65535, 1'b0, NoneYet},
    '{16'd32768, 16'd32768, 1'b0, NoneYet},
    '{16'd55440, 16'd45360, 1'b0, NoneYet},
    // Two zeros have no divisors at all, so they pair up with a total of zero.
    '{16'd0,     16'd0,     1'b0, NoneYet}
  };

  // Amicable pairs that fit in the value width, followed by perfect numbers.
  localparam int unsigned NumFriends = 12;
  localparam logic [VW-1:0] FriendA [NumFriends] = '{
    16'd220, 16'd1184, 16'd2620, 16'd5020, 16'd6232, 16'd10744, 16'd12285, 16'd17296,
    16'd6, 16'd28, 16'd496, 16'd8128
  };
  localparam logic [VW-1:0] FriendB [NumFriends] = '{
    16'd284, 16'd1210, 16'd2924, 16'd5564, 16'd6368, 16'd10856, 16'd14595, 16'd18416,
    16'd6, 16'd28, 16'd496, 16'd8128
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  logic [InWidth-1:0]  in_data;
  logic                out_valid;
  logic                out_ready;
  logic [OutWidth-1:0] out_data;

  // Predictor state.
  logic [CW-1:0] pairs_found;
  logic          best_seen;
  logic [7:0]    best_div_total;
  logic [VW-1:0] best_a;
  logic [VW-1:0] best_b;

  pair_result_t pending_results[$];
  int unsigned  requests_sent;
  int unsigned  results_seen;
  int unsigned  amicable_results;
  int unsigned  mismatches;
  logic         calm;
  logic         held_off_done;

  amicable_pair_checker i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void sum_proper_divisors(input int unsigned n,
                                              output int unsigned div_sum,
                                              output int unsigned div_cnt);
    int unsigned d;
    div_sum = 0;
    div_cnt = 0;
    if (n == 0) return;
    for (d = 1; d * d <= n; d++) begin
      if (n % d == 0) begin
        div_sum += d;
        div_cnt++;
        if (n / d != d) begin
          div_sum += n / d;
          div_cnt++;
        end
      end
    end
    // The number itself is not a proper divisor.
    div_sum -= n;
    div_cnt--;
  endfunction

  function automatic pair_result_t predict_pair(input logic [VW-1:0] a, input logic [VW-1:0] b);
    int unsigned sa, ca, sb, cb, total;
    pair_result_t r;
    sum_proper_divisors(a, sa, ca);
    sum_proper_divisors(b, sb, cb);
    total = ca + cb;
    if (total > apc_pkg::TotalMax) total = apc_pkg::TotalMax;
    r.amicable = (sa == b) && (sb == a);
    if (r.amicable) begin
      if (pairs_found != CountMax) pairs_found++;
      // Strictly fewer divisors only, so the first pair wins a tie.
      if (!best_seen || total < best_div_total) begin
        best_seen = 1'b1;
        best_div_total = total[7:0];
        best_a = a;
        best_b = b;
      end
    end
    r.count = pairs_found;
    r.best_valid = best_seen;
    r.fewest = best_div_total;
    r.best_first = best_a;
    r.best_second = best_b;
    return r;
  endfunction

  task automatic pick_pair(output logic [VW-1:0] a, output logic [VW-1:0] b);
    int unsigned kind, k, s, c;
    kind = $urandom_range(99);
    k = $urandom_range(NumFriends - 1);
    if (kind < 45) begin
      a = FriendA[k];
      b = FriendB[k];
      if ($urandom_range(1) == 1) begin
        a = FriendB[k];
        b = FriendA[k];
      end
    end else if (kind < 55) begin
      // The second value is the divisor sum of the first, so one side always matches.
      a = VW'($urandom_range(1, 20000));
      sum_proper_divisors(a, s, c);
      b = VW'(s);
    end else if (kind < 90) begin
      a = VW'($urandom_range(1, 4095));
      b = VW'($urandom_range(1, 4095));
    end else begin
      a = VW'($urandom);
      b = VW'($urandom);
    end
  endtask

  // Offers one request from a falling edge, idling at random unless calm, and returns
  // at the rising edge that takes it, so the caller offers the next one or lowers tvalid.
  task automatic send_pair(input logic [VW-1:0] a, input logic [VW-1:0] b,
                           input logic typed, input pair_result_t typed_result);
    logic [InWidth-1:0] word;
    pair_result_t       predicted;
    word = '0;
    word[2*VW-1:0] = {b, a};
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= word;
    do @(posedge clk_i); while (!in_ready);
    predicted = predict_pair(a, b);
    pending_results.push_back(typed ? typed_result : predicted);
    requests_sent++;
  endtask

  task automatic drop_request;
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off once the run is under way.
  initial begin
    out_ready = 1'b0;
    held_off_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off_done && results_seen >= HoldOffAfter) begin
        held_off_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      out_ready <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  always @(posedge clk_i) begin
    pair_result_t got, want;
    if (rst_ni && out_valid && out_ready) begin
      got = out_data[$bits(pair_result_t)-1:0];
      results_seen++;
      if (got.amicable) amicable_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("Result %0d arrived with no request outstanding.", results_seen);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("Result %0d differs (expected / actual):", results_seen);
            $display("  amicable %0b / %0b, count %0d / %0d, best_valid %0b / %0b",
                     want.amicable, got.amicable, want.count, got.count,
                     want.best_valid, got.best_valid);
            $display("  fewest %0d / %0d, best pair %0d,%0d / %0d,%0d",
                     want.fewest, got.fewest, want.best_first, want.best_second,
                     got.best_first, got.best_second);
          end
        end
      end
    end
  end

  // Ends the run if no request and no result moves for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("No transfer for %0d cycles, giving up.", StallLimit);
    $display("amicable_pair_checker verification failed");
    $finish;
  end

  initial begin
    logic [VW-1:0] a, b;
    int unsigned   i;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    pairs_found = '0;
    best_seen = 1'b0;
    best_div_total = '0;
    best_a = '0;
    best_b = '0;
    requests_sent = 0;
    results_seen = 0;
    amicable_results = 0;
    mismatches = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < NumDirected; i++) begin
      send_pair(DirectedRows[i].a_value, DirectedRows[i].b_value,
                DirectedRows[i].typed, DirectedRows[i].result);
    end

    for (i = 0; i < NumRandom; i++) begin
      calm = (i >= CalmFrom) && (i < CalmTo);
      if (i == PauseAt) begin
        drop_request();
        wait (pending_results.size() == 0);
      end
      pick_pair(a, b);
      send_pair(a, b, 1'b0, NoneYet);
    end
    drop_request();

    wait (pending_results.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Ran %0d requests: extremes, zero and one, amicable and perfect pairs,",
             requests_sent);
    $display("random pairs and an output hold-off; %0d amicable, final count %0d.",
             amicable_results, pairs_found);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("amicable_pair_checker verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, pending_results.size());
      $display("amicable_pair_checker verification failed");
    end
    $finish;
  end

endmodule

// ===== amicable_pair_checker.f =====
rtl/apc_pkg.sv
rtl/apc_div.sv
rtl/apc_lane.sv
rtl/apc_merge.sv
rtl/amicable_pair_checker.sv
tb/amicable_pair_checker_tb.sv
